// ----- hdl/b64f_pkg.sv -----
package b64f_pkg;

    // register indexes on the configuration port
    localparam logic REG_WORD_MODE = 1'b0;
    localparam logic REG_VALUE_COUNT = 1'b1;

    // one quantum after decode, carried from the front stage to the packer
    typedef struct packed {
        logic [23:0] bytes3;  // first decoded byte in bits 23:16
        logic        start;
    } quantum_t;

    // base64 character to sextet; anything outside the alphabet is zero
    function automatic logic [5:0] sextet(input logic [7:0] ch);
        logic [5:0] r;
        r = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) r = 6'(ch - 8'h41);
        else if (ch >= 8'h61 && ch <= 8'h7A) r = 6'(ch - 8'h61 + 8'd26);
        else if (ch >= 8'h30 && ch <= 8'h39) r = 6'(ch - 8'h30 + 8'd52);
        else if (ch == 8'h2B) r = 6'd62;
        else if (ch == 8'h2F) r = 6'd63;
        return r;
    endfunction

    // exact float32 to double widening
    function automatic logic [63:0] widen_single(input logic [31:0] w);
        logic [7:0]  ex;
        logic [22:0] man;
        logic [22:0] nman;
        logic [4:0]  lz;
        logic        found;
        logic [10:0] dex;
        logic [63:0] r;
        ex = w[30:23];
        man = w[22:0];
        lz = 5'd0;
        found = 1'b0;
        for (int i = 22; i >= 0; i--) begin
            if (!found && man[i]) begin
                found = 1'b1;
                lz = 5'(22 - i);
            end
        end
        nman = 23'(man << (lz + 5'd1));
        dex = 11'd0;
        r = {w[31], 63'd0};
        if (ex == 8'hFF) begin
            r = {w[31], 11'h7FF, (man != 23'd0), man[21:0], 29'd0};
            r[51] = (man != 23'd0) | man[22];
        end else if (ex == 8'd0) begin
            if (man != 23'd0) begin
                dex = 11'd896 - 11'(lz);
                r = {w[31], dex, nman, 29'd0};
            end
        end else begin
            dex = 11'(ex) + 11'd896;
            r = {w[31], dex, man, 29'd0};
        end
        return r;
    endfunction

endpackage

// ----- hdl/b64f_front.sv -----
module b64f_front
    import b64f_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        advance,
    input  logic [32:0] in_data,
    output logic        q_valid_reg,
    output quantum_t    q_reg
);

    logic [23:0] bits;

    // four sextets to three bytes
    assign bits = {sextet(in_data[7:0]), sextet(in_data[15:8]),
                   sextet(in_data[23:16]), sextet(in_data[31:24])};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            q_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            q_reg.bytes3 <= bits;
            q_reg.start  <= in_data[32];
        end
    end

endmodule

// ----- hdl/b64f_pack.sv -----
module b64f_pack
    import b64f_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  quantum_t              q,
    input  logic                  advance,
    input  logic                  word_mode,
    input  logic [COUNT_BITS-1:0] value_count,
    output logic                  out_valid_reg,
    output logic [63:0]           out_bits_reg,
    output logic                  out_last_reg
);

    logic [55:0]           pend_reg, pend_next;
    logic [2:0]            pcnt_reg, pcnt_next;
    logic [COUNT_BITS-1:0] emit_reg, emit_next;
    logic [79:0]           buf_w;
    logic [55:0]           base;
    logic [2:0]            base_cnt;
    logic [3:0]            total;
    logic [3:0]            wsize;
    logic                  have_word;
    logic                  emit;
    logic [63:0]           word;
    logic [COUNT_BITS-1:0] emit_inc;

    // append three bytes behind the pending ones, oldest at bit 0
    always_comb
    begin
        base     = q.start ? 56'd0 : pend_reg;
        base_cnt = q.start ? 3'd0 : pcnt_reg;
        buf_w    = {24'd0, base} |
                   (80'({q.bytes3[7:0], q.bytes3[15:8], q.bytes3[23:16]})
                    << {base_cnt, 3'b000});
        total    = 4'(base_cnt) + 4'd3;
        wsize    = word_mode ? 4'd8 : 4'd4;
        have_word = total >= wsize;
        emit_inc = (q.start ? '0 : emit_reg) + 1'b1;
        emit     = have_word && ((q.start ? '0 : emit_reg) < value_count);
        word     = word_mode ? buf_w[63:0] : widen_single(buf_w[31:0]);
        if (have_word)
        begin
            // drop the word's bytes, the rest move down to bit 0
            pend_next = word_mode ? {40'd0, buf_w[79:64]} : {8'd0, buf_w[79:32]};
            pcnt_next = 3'(total - wsize);
        end
        else
        begin
            pend_next = buf_w[55:0];
            pcnt_next = 3'(total);
        end
        emit_next = emit ? emit_inc : (q.start ? '0 : emit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            pcnt_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= q_valid && emit;
            if (q_valid)
            begin
                pend_reg <= pend_next;
                pcnt_reg <= pcnt_next;
                emit_reg <= emit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && q_valid && emit)
        begin
            out_bits_reg <= word;
            out_last_reg <= (emit_inc == value_count);
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= 3'd7)
        else $error("pending count out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(emit_reg) && $stable(pcnt_reg))
        else $error("state moved during stall");
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && q_valid && emit && !q.start) |=> emit_reg == $past(emit_reg) + 1'b1)
        else $error("emitted count did not step");

endmodule

// ----- hdl/base64_to_float_words_decoder.sv -----
// Path: an input beat is registered in the front register, then in the packer register, before its result beat.
// Throughput: one quantum per cycle; the front register and the packer
// register advance together whenever the result register is free or taken.
// Reset (rst_n, asynchronous, active low) clears the byte assembler, the
// emitted count, the mode and value count registers and all valid flags.
module base64_to_float_words_decoder
    import b64f_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // char_a, char_b, char_c, char_d
    input  logic        s_axis_tuser,  // start_record
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // value_bits
    output logic        m_axis_tlast,  // last_value
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    logic                  mode_reg;
    logic [COUNT_BITS-1:0] vcount_reg;
    logic                  advance;
    logic                  q_valid;
    quantum_t              q;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            vcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WORD_MODE:   mode_reg <= cfg_data[0];
                REG_VALUE_COUNT: vcount_reg <= COUNT_BITS'(cfg_data);
                default:         mode_reg <= mode_reg;
            endcase
        end
    end

    b64f_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .advance     (advance),
        .in_data     ({s_axis_tuser, s_axis_tdata}),
        .q_valid_reg (q_valid),
        .q_reg       (q)
    );

    b64f_pack #(.COUNT_BITS(COUNT_BITS)) u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q             (q),
        .advance       (advance),
        .word_mode     (mode_reg),
        .value_count   (vcount_reg),
        .out_valid_reg (m_axis_tvalid),
        .out_bits_reg  (m_axis_tdata),
        .out_last_reg  (m_axis_tlast)
    );

endmodule
